// ===== hdl/ipdt_pkg.sv =====
// ---------------------------------------------------------------------------
// ipdt_pkg
// Shared types and constants of the pulse-distance IR transceiver.
// ---------------------------------------------------------------------------
`default_nettype none

package ipdt_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_EDGE  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_START_BURST = 3'd0;
	localparam logic [2:0] REG_ONE_BURST   = 3'd1;
	localparam logic [2:0] REG_ZERO_BURST  = 3'd2;
	localparam logic [2:0] REG_GAP         = 3'd3;
	localparam logic [2:0] REG_SYNC_GAP    = 3'd4;
	localparam logic [2:0] REG_ZERO_CENTER = 3'd5;
	localparam logic [2:0] REG_ONE_CENTER  = 3'd6;
	localparam logic [2:0] REG_MARGIN      = 3'd7;

	// Start step plus eight data bits.
	localparam logic [3:0] TX_STEPS = 4'd9;
	localparam logic [3:0] RX_BITS  = 4'd8;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  tx_byte;
		logic [31:0] timestamp_us;
		logic        rx_level;
	} ipdt_in_t;

	typedef struct packed {
		logic       carrier_on;
		logic       tx_accepted;
		logic       tx_busy;
		logic [7:0] rx_byte;
		logic       rx_valid;
	} ipdt_out_t;

	typedef struct packed {
		logic [7:0]  start_burst_ticks;
		logic [7:0]  one_burst_ticks;
		logic [7:0]  zero_burst_ticks;
		logic [7:0]  gap_ticks;
		logic [15:0] sync_gap_us;
		logic [15:0] zero_center_us;
		logic [15:0] one_center_us;
		logic [15:0] window_margin_us;
	} ipdt_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/ipdt_tx.sv =====
// ---------------------------------------------------------------------------
// ipdt_tx
// Transmit sequencer: burst and gap counters, start burst, eight data bits.
// ---------------------------------------------------------------------------
`default_nettype none

module ipdt_tx (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [1:0]        func,
	input  wire logic [7:0]        tx_byte,
	input  ipdt_pkg::ipdt_cfg_t    cfg,
	output logic                   carrier_next,
	output logic                   pending_next,
	output logic                   accepted,
	output logic                   pending
);
	import ipdt_pkg::*;

	logic       carrier_q;
	logic       pending_q;
	logic [3:0] steps_q, steps_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] burst_q, burst_d;
	logic [7:0] gap_q, gap_d;
	logic       carrier_d, pending_d, accepted_d;

	always_comb begin
		carrier_d  = carrier_q;
		pending_d  = pending_q;
		steps_d    = steps_q;
		shift_d    = shift_q;
		burst_d    = burst_q;
		gap_d      = gap_q;
		accepted_d = 1'b0;
		case (func)
			FUNC_TICK: begin
				if (burst_q != 8'd0) begin
					burst_d   = burst_q - 8'd1;
					carrier_d = 1'b1;
				end else if (gap_q != 8'd0) begin
					gap_d     = gap_q - 8'd1;
					carrier_d = 1'b0;
				end else if (steps_q == TX_STEPS) begin
					burst_d = cfg.start_burst_ticks;
					gap_d   = cfg.gap_ticks;
					steps_d = steps_q - 4'd1;
				end else if (steps_q != 4'd0) begin
					burst_d = shift_q[7] ? cfg.one_burst_ticks : cfg.zero_burst_ticks;
					gap_d   = cfg.gap_ticks;
					shift_d = {shift_q[6:0], 1'b0};
					steps_d = steps_q - 4'd1;
				end else if (pending_q) begin
					carrier_d = 1'b0;
					pending_d = 1'b0;
				end
			end
			FUNC_WRITE: begin
				// A write while a send is pending is refused and changes nothing.
				if (!pending_q) begin
					shift_d    = tx_byte;
					steps_d    = TX_STEPS;
					pending_d  = 1'b1;
					carrier_d  = 1'b1;
					accepted_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= 1'b0;
			pending_q <= 1'b0;
			steps_q   <= 4'd0;
			shift_q   <= 8'd0;
			burst_q   <= 8'd0;
			gap_q     <= 8'd0;
		end else if (step) begin
			carrier_q <= carrier_d;
			pending_q <= pending_d;
			steps_q   <= steps_d;
			shift_q   <= shift_d;
			burst_q   <= burst_d;
			gap_q     <= gap_d;
		end
	end

	assign carrier_next = carrier_d;
	assign pending_next = pending_d;
	assign accepted     = accepted_d;
	assign pending      = pending_q;

endmodule

`default_nettype wire

// ===== hdl/ipdt_rx.sv =====
// ---------------------------------------------------------------------------
// ipdt_rx
// Receive decoder: edge spacing windows, bit shifter and byte latch.
// ---------------------------------------------------------------------------
`default_nettype none

module ipdt_rx (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              is_edge,
	input  wire logic [31:0]       timestamp_us,
	input  wire logic              rx_level,
	input  wire logic              send_busy,
	input  ipdt_pkg::ipdt_cfg_t    cfg,
	output logic                   done,
	output logic [7:0]             byte_out
);
	import ipdt_pkg::*;

	logic [15:0] last_q;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  bits_q, bits_d;
	logic        latched_q, latched_d;
	logic [7:0]  data_q, data_d;
	logic [15:0] now, elapsed, dev_zero, dev_one;
	logic        in_zero, in_one, eval, done_d;

	assign now     = timestamp_us[15:0];
	assign elapsed = now - last_q;

	assign dev_zero = (elapsed >= cfg.zero_center_us) ? elapsed - cfg.zero_center_us
	                                                  : cfg.zero_center_us - elapsed;
	assign dev_one  = (elapsed >= cfg.one_center_us) ? elapsed - cfg.one_center_us
	                                                 : cfg.one_center_us - elapsed;
	assign in_zero  = dev_zero < cfg.window_margin_us;
	assign in_one   = dev_one < cfg.window_margin_us;

	// Only rising edges count, and the own transmission is not heard.
	assign eval = is_edge && rx_level && !send_busy;

	always_comb begin
		shift_d   = shift_q;
		bits_d    = bits_q;
		latched_d = latched_q;
		data_d    = data_q;
		done_d    = 1'b0;
		if (eval) begin
			if (elapsed > cfg.sync_gap_us) begin
				shift_d   = 8'd0;
				bits_d    = RX_BITS;
				latched_d = 1'b0;
			end
			// When both windows overlap, one edge may shift in two bits.
			if (in_zero && bits_d != 4'd0) begin
				shift_d = {shift_d[6:0], 1'b0};
				bits_d  = bits_d - 4'd1;
			end
			if (in_one && bits_d != 4'd0) begin
				shift_d = {shift_d[6:0], 1'b1};
				bits_d  = bits_d - 4'd1;
			end
			// After reset no bits are left, so the first counted edge within the sync gap reports a zero byte.
			if (bits_d == 4'd0 && !latched_d) begin
				data_d    = shift_d;
				latched_d = 1'b1;
				done_d    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 16'd0;
			shift_q   <= 8'd0;
			bits_q    <= 4'd0;
			latched_q <= 1'b0;
			data_q    <= 8'd0;
		end else if (step) begin
			if (is_edge) begin
				last_q <= now;
			end
			shift_q   <= shift_d;
			bits_q    <= bits_d;
			latched_q <= latched_d;
			data_q    <= data_d;
		end
	end

	assign done     = done_d;
	assign byte_out = done_d ? data_d : 8'd0;

endmodule

`default_nettype wire

// ===== hdl/ir_pulse_distance_transceiver.sv =====
// Path: an accepted item is held in the input register, and its result in the result register.
// Throughput: one item per clock cycle; the input register advances whenever the
// result register is empty or its result is being taken.
// Reset: arst_n clears the handshake, the transmitter and receiver state and loads the
// configuration registers with their default values; the carrier is off.
// ---------------------------------------------------------------------------
// ir_pulse_distance_transceiver
// Pulse-distance IR transmitter and receiver with one result per input item.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_transceiver (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  ipdt_pkg::ipdt_in_t       in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ipdt_pkg::ipdt_out_t      out_item,
	input  wire logic                wr_en,
	input  wire logic [2:0]          wr_index,
	input  wire logic [15:0]         wr_data
);
	import ipdt_pkg::*;

	ipdt_cfg_t cfg_q;
	ipdt_in_t  item_s1;
	logic      valid_s1;
	ipdt_out_t result_q;
	logic      result_valid_q;
	logic      adv_s1, step;
	logic      tx_carrier_next, tx_busy_next, tx_accepted, send_busy;
	logic      rx_done;
	logic [7:0] rx_byte_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_burst_ticks <= 8'd48;
			cfg_q.one_burst_ticks   <= 8'd32;
			cfg_q.zero_burst_ticks  <= 8'd16;
			cfg_q.gap_ticks         <= 8'd16;
			cfg_q.sync_gap_us       <= 16'd2000;
			cfg_q.zero_center_us    <= 16'd496;
			cfg_q.one_center_us     <= 16'd760;
			cfg_q.window_margin_us  <= 16'd100;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_BURST: cfg_q.start_burst_ticks <= wr_data[7:0];
				REG_ONE_BURST:   cfg_q.one_burst_ticks   <= wr_data[7:0];
				REG_ZERO_BURST:  cfg_q.zero_burst_ticks  <= wr_data[7:0];
				REG_GAP:         cfg_q.gap_ticks         <= wr_data[7:0];
				REG_SYNC_GAP:    cfg_q.sync_gap_us       <= wr_data;
				REG_ZERO_CENTER: cfg_q.zero_center_us    <= wr_data;
				REG_ONE_CENTER:  cfg_q.one_center_us     <= wr_data;
				REG_MARGIN:      cfg_q.window_margin_us  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// The input register is processed when the result register can take its result.
	assign adv_s1   = !result_valid_q || !out_stall;
	assign step     = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	ipdt_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.func         (item_s1.func),
		.tx_byte      (item_s1.tx_byte),
		.cfg          (cfg_q),
		.carrier_next (tx_carrier_next),
		.pending_next (tx_busy_next),
		.accepted     (tx_accepted),
		.pending      (send_busy)
	);

	ipdt_rx u_rx (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.is_edge      (item_s1.func == FUNC_EDGE),
		.timestamp_us (item_s1.timestamp_us),
		.rx_level     (item_s1.rx_level),
		.send_busy    (send_busy),
		.cfg          (cfg_q),
		.done         (rx_done),
		.byte_out     (rx_byte_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.carrier_on  <= tx_carrier_next;
			result_q.tx_accepted <= tx_accepted;
			result_q.tx_busy     <= tx_busy_next;
			result_q.rx_byte     <= rx_byte_out;
			result_q.rx_valid    <= rx_done;
		end
	end

	assign out_valid = result_valid_q;
	assign out_item  = result_q;

	// A received byte can only complete while nothing is being sent.
	a_rx_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rx_valid |-> !out_item.tx_busy)
		else $error("byte received while a send is pending");

	// A taken write starts the carrier and marks the transmitter busy.
	a_write_starts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.tx_accepted |-> out_item.carrier_on && out_item.tx_busy)
		else $error("accepted write did not start a send");

	// An item held in the input register is not lost while the output is blocked.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1))
		else $error("held input item was dropped");

endmodule

`default_nettype wire

// ===== tb/ir_pulse_distance_transceiver_test.sv =====
// ---------------------------------------------------------------------------
// ir_pulse_distance_transceiver_test
// Self-checking testbench for the pulse-distance IR transceiver. Ticks, write
// requests and receive edges are sent in random bursts while the output side
// stalls on its own pattern. A behavioral copy of the transmitter and receiver
// predicts the status returned for every item, and each returned item is
// compared field by field. Directed cases come first, then well-formed
// frames and send sessions with random content, mixed with stray items.
// ---------------------------------------------------------------------------

module ir_pulse_distance_transceiver_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ipdt_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 4;
	localparam int LONG_HOLD      = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_GOAL      = 1850;

	// The package names only the three defined item kinds.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam ipdt_cfg_t CFG_DEFAULT = '{
		start_burst_ticks: 8'd48,
		one_burst_ticks:   8'd32,
		zero_burst_ticks:  8'd16,
		gap_ticks:         8'd16,
		sync_gap_us:       16'd2000,
		zero_center_us:    16'd496,
		one_center_us:     16'd760,
		window_margin_us:  16'd100
	};

	typedef enum int {FLOW_FREE, FLOW_PATCHY, FLOW_CHOKED} flow_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	ipdt_in_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	ipdt_out_t   out_item;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [15:0] wr_data = '0;

	// Predicted link state.
	ipdt_cfg_t   link_cfg = CFG_DEFAULT;
	logic [15:0] prev_edge_us = '0;
	logic [7:0]  rx_sr = '0;
	logic [3:0]  rx_left = '0;
	logic        rx_done = 1'b0;
	logic [7:0]  rx_word = '0;
	logic        tx_busy_st = 1'b0;
	logic [3:0]  tx_steps = '0;
	logic [7:0]  tx_sr = '0;
	logic [7:0]  burst_cnt = '0;
	logic [7:0]  gap_cnt = '0;
	logic        carrier_st = 1'b0;

	ipdt_out_t   awaited_status[$];
	int          errors = 0;
	int          items_sent = 0;
	int          burst_items = 0;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	int          quiet_cycles = 0;

	ir_pulse_distance_transceiver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic near_center(logic [15:0] spacing, logic [15:0] center);
		logic [15:0] dev;
		dev = (spacing >= center) ? spacing - center : center - spacing;
		return dev < link_cfg.window_margin_us;
	endfunction

	// Advances the predicted link by one item and returns its status.
	function automatic ipdt_out_t link_status_after(ipdt_in_t it);
		ipdt_out_t   status;
		logic [15:0] now_us;
		logic [15:0] spacing;
		logic        took;
		logic        latched_now;
		took = 1'b0;
		latched_now = 1'b0;
		case (it.func)
			FUNC_TICK: begin
				if (burst_cnt != 0) begin
					burst_cnt = burst_cnt - 8'd1;
					carrier_st = 1'b1;
				end else if (gap_cnt != 0) begin
					gap_cnt = gap_cnt - 8'd1;
					carrier_st = 1'b0;
				end else if (tx_steps == TX_STEPS) begin
					burst_cnt = link_cfg.start_burst_ticks;
					gap_cnt = link_cfg.gap_ticks;
					tx_steps = TX_STEPS - 4'd1;
				end else if (tx_steps != 0) begin
					burst_cnt = tx_sr[7] ? link_cfg.one_burst_ticks : link_cfg.zero_burst_ticks;
					gap_cnt = link_cfg.gap_ticks;
					tx_sr = tx_sr << 1;
					tx_steps = tx_steps - 4'd1;
				end else if (tx_busy_st) begin
					carrier_st = 1'b0;
					tx_busy_st = 1'b0;
				end
			end
			FUNC_WRITE: begin
				if (!tx_busy_st) begin
					tx_sr = it.tx_byte;
					tx_steps = TX_STEPS;
					tx_busy_st = 1'b1;
					carrier_st = 1'b1;
					took = 1'b1;
				end
			end
			FUNC_EDGE: begin
				now_us = it.timestamp_us[15:0];
				spacing = now_us - prev_edge_us;
				prev_edge_us = now_us;
				if (it.rx_level && !tx_busy_st) begin
					if (spacing > link_cfg.sync_gap_us) begin
						rx_sr = '0;
						rx_left = RX_BITS;
						rx_done = 1'b0;
					end
					if (near_center(spacing, link_cfg.zero_center_us) && rx_left != 0) begin
						rx_sr = rx_sr << 1;
						rx_left = rx_left - 4'd1;
					end
					if (near_center(spacing, link_cfg.one_center_us) && rx_left != 0) begin
						rx_sr = {rx_sr[6:0], 1'b1};
						rx_left = rx_left - 4'd1;
					end
					if (rx_left == 0 && !rx_done) begin
						rx_word = rx_sr;
						rx_done = 1'b1;
						latched_now = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		status.carrier_on = carrier_st;
		status.tx_accepted = took;
		status.tx_busy = tx_busy_st;
		status.rx_byte = latched_now ? rx_word : 8'd0;
		status.rx_valid = latched_now;
		return status;
	endfunction

	function automatic ipdt_in_t random_item(logic [1:0] kind);
		ipdt_in_t it;
		it.func = kind;
		it.tx_byte = 8'($urandom);
		it.timestamp_us = $urandom;
		it.rx_level = 1'($urandom);
		return it;
	endfunction

	// The sender works in bursts; a gap may open before the first item of a burst.
	task automatic send_item(input ipdt_in_t it);
		int pause;
		pause = 0;
		if (burst_items == 0) begin
			burst_items = $urandom_range(1, 24);
			if (gaps_on && $urandom_range(0, 3) != 0)
				pause = $urandom_range(1, 6);
		end
		burst_items--;
		if (pause != 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		awaited_status.push_back(link_status_after(it));
		items_sent++;
	endtask

	// Places a receive edge at the given spacing after the previous edge.
	task automatic send_edge(input logic [15:0] spacing, input logic level);
		ipdt_in_t it;
		it = random_item(FUNC_EDGE);
		it.timestamp_us[15:0] = prev_edge_us + spacing;
		it.rx_level = level;
		send_item(it);
	endtask

	task automatic drain_tx();
		while (tx_busy_st) send_item(random_item(FUNC_TICK));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_START_BURST: link_cfg.start_burst_ticks = value[7:0];
			REG_ONE_BURST:   link_cfg.one_burst_ticks = value[7:0];
			REG_ZERO_BURST:  link_cfg.zero_burst_ticks = value[7:0];
			REG_GAP:         link_cfg.gap_ticks = value[7:0];
			REG_SYNC_GAP:    link_cfg.sync_gap_us = value;
			REG_ZERO_CENTER: link_cfg.zero_center_us = value;
			REG_ONE_CENTER:  link_cfg.one_center_us = value;
			default:         link_cfg.window_margin_us = value;
		endcase
	endtask

	// The upper byte of an 8-bit register write carries noise that must be dropped.
	task automatic apply_config(input ipdt_cfg_t c);
		wait_idle();
		write_reg(REG_START_BURST, {8'($urandom), c.start_burst_ticks});
		write_reg(REG_ONE_BURST, {8'($urandom), c.one_burst_ticks});
		write_reg(REG_ZERO_BURST, {8'($urandom), c.zero_burst_ticks});
		write_reg(REG_GAP, {8'($urandom), c.gap_ticks});
		write_reg(REG_SYNC_GAP, c.sync_gap_us);
		write_reg(REG_ZERO_CENTER, c.zero_center_us);
		write_reg(REG_ONE_CENTER, c.one_center_us);
		write_reg(REG_MARGIN, c.window_margin_us);
	endtask

	// Short bursts keep a send session to at most 145 ticks.
	task automatic random_link_config();
		ipdt_cfg_t c;
		int margin;
		int zero_c;
		int one_c;
		c.start_burst_ticks = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) :
			$urandom_range(0, 3));
		c.one_burst_ticks = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) :
			$urandom_range(0, 3));
		c.zero_burst_ticks = 8'($urandom_range(0, 3));
		c.gap_ticks = 8'($urandom_range(0, 3));
		margin = $urandom_range(1, 250);
		zero_c = $urandom_range(margin, 1500);
		if ($urandom_range(0, 5) == 0)
			one_c = zero_c + $urandom_range(0, margin);
		else
			one_c = zero_c + $urandom_range(2 * margin, 1500);
		c.sync_gap_us = 16'(one_c + margin + $urandom_range(0, 4000));
		c.zero_center_us = 16'(zero_c);
		c.one_center_us = 16'(one_c);
		c.window_margin_us = 16'(margin);
		apply_config(c);
	endtask

	// A restart pause on most frames and eight bit spacings, with the odd glitch or lost bit.
	task automatic rx_frame();
		logic [7:0]  data;
		logic [15:0] spacing;
		int          lo;
		int          center;
		int          dev;
		drain_tx();
		data = 8'($urandom);
		if ($urandom_range(0, 9) != 0) begin
			lo = link_cfg.sync_gap_us + 1;
			if (lo > 65535)
				spacing = 16'hFFFF;
			else
				spacing = 16'($urandom_range(lo, (lo + 4000 > 65535) ? 65535 : lo + 4000));
			send_edge(spacing, 1'b1);
		end
		for (int b = 7; b >= 0; b--) begin
			if ($urandom_range(0, 24) == 0)
				send_edge(16'($urandom), 1'($urandom));
			if ($urandom_range(0, 29) == 0)
				continue;
			center = data[b] ? link_cfg.one_center_us : link_cfg.zero_center_us;
			dev = (link_cfg.window_margin_us == 0) ? 0 :
				$urandom_range(0, link_cfg.window_margin_us - 1);
			spacing = $urandom_range(0, 1) ? 16'(center + dev) : 16'(center - dev);
			send_edge(spacing, 1'b1);
		end
	endtask

	// One write and the ticks that carry it out, with stray items mixed in.
	task automatic tx_session();
		int pick;
		drain_tx();
		send_item(random_item(FUNC_WRITE));
		while (tx_busy_st) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				send_item(random_item(FUNC_WRITE));
			else if (pick == 1)
				send_edge(16'($urandom), 1'($urandom));
			else if (pick == 2)
				send_item(random_item(FUNC_UNUSED));
			else
				send_item(random_item(FUNC_TICK));
		end
	endtask

	task automatic stray_edges(input int count);
		logic [15:0] spacing;
		drain_tx();
		repeat (count) begin
			case ($urandom_range(0, 4))
				0:       spacing = 16'h0000;
				1:       spacing = 16'hFFFF;
				2:       spacing = link_cfg.zero_center_us;
				3:       spacing = link_cfg.one_center_us;
				default: spacing = 16'($urandom);
			endcase
			send_edge(spacing, $urandom_range(0, 5) != 0);
		end
	endtask

	task automatic stray_items(input int count);
		repeat (count) send_item(random_item(2'($urandom_range(0, 3))));
	endtask

	task automatic test_power_on_edges();
		// Nothing is latched after reset, so the first evaluated edge within the sync gap reports a zero byte.
		send_edge(16'd100, 1'b1);
		send_edge(16'd496, 1'b1);
		send_edge(16'hFFFF, 1'b0);
		send_item(random_item(FUNC_UNUSED));
		send_item(random_item(FUNC_TICK));
	endtask

	task automatic test_directed_send();
		ipdt_cfg_t c;
		ipdt_in_t  it;
		c = CFG_DEFAULT;
		c.start_burst_ticks = 8'd0;
		c.one_burst_ticks = 8'd1;
		c.zero_burst_ticks = 8'd0;
		c.gap_ticks = 8'd1;
		apply_config(c);
		it = random_item(FUNC_WRITE);
		it.tx_byte = 8'h81;
		send_item(it);
		// A second write while the first is pending is refused.
		it.tx_byte = 8'h7E;
		send_item(it);
		send_edge(16'd2500, 1'b1);
		drain_tx();
	endtask

	task automatic test_directed_windows();
		ipdt_cfg_t c;
		ipdt_in_t  it;
		apply_config(CFG_DEFAULT);
		send_edge(16'd2001, 1'b1);
		send_edge(16'd2000, 1'b1);
		send_edge(16'd596, 1'b1);
		send_edge(16'd595, 1'b1);
		send_edge(16'd397, 1'b1);
		send_edge(16'd660, 1'b1);
		send_edge(16'd661, 1'b1);
		send_edge(16'd859, 1'b1);
		send_edge(16'd0, 1'b1);
		// With both windows on the same spacing, each edge shifts in a zero and a one.
		c = CFG_DEFAULT;
		c.zero_center_us = 16'd600;
		c.one_center_us = 16'd600;
		c.window_margin_us = 16'd50;
		apply_config(c);
		send_edge(16'd2500, 1'b1);
		repeat (4) send_edge(16'd600, 1'b1);
		it = random_item(FUNC_EDGE);
		it.timestamp_us = '1;
		it.rx_level = 1'b1;
		send_item(it);
		it.timestamp_us = '0;
		send_item(it);
	endtask

	task automatic test_counter_extremes();
		ipdt_cfg_t c;
		c = link_cfg;
		c.start_burst_ticks = 8'hFF;
		c.one_burst_ticks = 8'hFF;
		c.zero_burst_ticks = 8'hFF;
		c.gap_ticks = 8'hFF;
		apply_config(c);
		send_item(random_item(FUNC_WRITE));
		send_item(random_item(FUNC_TICK));
		// Run out the full start burst and gap, then finish the bits with empty counts.
		while (burst_cnt != 0 || gap_cnt != 0) send_item(random_item(FUNC_TICK));
		c.start_burst_ticks = 8'h00;
		c.one_burst_ticks = 8'h00;
		c.zero_burst_ticks = 8'h00;
		c.gap_ticks = 8'h00;
		apply_config(c);
		drain_tx();
	endtask

	task automatic test_window_extremes();
		ipdt_cfg_t c;
		c = link_cfg;
		c.sync_gap_us = 16'h0000;
		c.window_margin_us = 16'h0000;
		apply_config(c);
		stray_edges(12);
		c.sync_gap_us = 16'hFFFF;
		c.window_margin_us = 16'hFFFF;
		c.zero_center_us = 16'h0000;
		c.one_center_us = 16'hFFFF;
		apply_config(c);
		stray_edges(12);
		c.sync_gap_us = 16'h8000;
		c.window_margin_us = 16'h0001;
		apply_config(c);
		stray_edges(12);
	endtask

	// Items keep coming back to back while the output side holds off.
	task automatic test_receiver_hold_off();
		gaps_on = 1'b0;
		hold_req = 1'b1;
		repeat (48) send_item(random_item(2'($urandom_range(0, 2))));
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int pick;
		random_link_config();
		while (items_sent < ITEM_GOAL) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				rx_frame();
			else if (pick < 65)
				tx_session();
			else if (pick < 85)
				stray_items($urandom_range(1, 8));
			else if (pick < 93)
				stray_edges($urandom_range(2, 10));
			else
				random_link_config();
		end
	endtask

	initial begin : receiver_stall_pattern
		flow_t mode;
		int    run_cycles;
		mode = FLOW_FREE;
		run_cycles = 0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (run_cycles == 0) begin
					mode = flow_t'($urandom_range(0, 2));
					run_cycles = $urandom_range(4, 40);
				end
				run_cycles--;
				case (mode)
					FLOW_FREE:   out_stall <= 1'b0;
					FLOW_PATCHY: out_stall <= 1'($urandom);
					default:     out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic report_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : status_check
		ipdt_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_status.size() == 0) begin
				$display("%0t: unexpected item, expected none, got %h", $time, out_item);
				errors++;
			end else begin
				want = awaited_status.pop_front();
				report_field("carrier_on", 8'(want.carrier_on), 8'(out_item.carrier_on));
				report_field("tx_accepted", 8'(want.tx_accepted), 8'(out_item.tx_accepted));
				report_field("tx_busy", 8'(want.tx_busy), 8'(out_item.tx_busy));
				report_field("rx_byte", want.rx_byte, out_item.rx_byte);
				report_field("rx_valid", 8'(want.rx_valid), 8'(out_item.rx_valid));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_edges();
		test_directed_send();
		test_directed_windows();
		test_counter_extremes();
		test_window_extremes();
		test_receiver_hold_off();
		test_random_traffic();
		wait_idle();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ipdt_pkg.sv
hdl/ipdt_tx.sv
hdl/ipdt_rx.sv
hdl/ir_pulse_distance_transceiver.sv
tb/ir_pulse_distance_transceiver_test.sv
